// ===== src/rbpk_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpk_pkg: shared types and constants for the rigid body kinematics unit
// Command codes, beat structs, body table words and the CORDIC angle table.
// ----------------------------------------------------------------------------
package rbpk_pkg;

	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_FORCE = 3'd1;
	localparam logic [2:0] CMD_VEL   = 3'd2;
	localparam logic [2:0] CMD_WORLD = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// 1/K in Q2.30
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

	typedef struct packed {
		logic [2:0]          cmd;
		logic [5:0]          body;
		logic signed [31:0]  point_x;
		logic signed [31:0]  point_y;
		logic signed [31:0]  force_x;
		logic signed [31:0]  force_y;
		logic signed [31:0]  load_pos_x;
		logic signed [31:0]  load_pos_y;
		logic [15:0]         load_angle;
		logic signed [31:0]  load_vel_x;
		logic signed [31:0]  load_vel_y;
		logic signed [31:0]  load_omega;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic signed [31:0] result_torque;
	} result_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        angle;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] omega;
	} kin_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] torque;
	} acc_t;

	typedef struct packed {
		logic init;
		logic step;
	} cord_ctl_t;

	// arctan(2^-i), full turn = 2^32
	function automatic logic signed [32:0] atan_at(input logic [4:0] i);
		logic signed [32:0] v;
		unique case (i)
			5'd0:  v = 33'sd536870912;
			5'd1:  v = 33'sd316933406;
			5'd2:  v = 33'sd167458907;
			5'd3:  v = 33'sd85004756;
			5'd4:  v = 33'sd42667331;
			5'd5:  v = 33'sd21354465;
			5'd6:  v = 33'sd10679838;
			5'd7:  v = 33'sd5340245;
			5'd8:  v = 33'sd2670163;
			5'd9:  v = 33'sd1335087;
			5'd10: v = 33'sd667544;
			5'd11: v = 33'sd333772;
			5'd12: v = 33'sd166886;
			5'd13: v = 33'sd83443;
			5'd14: v = 33'sd41721;
			5'd15: v = 33'sd20860;
			5'd16: v = 33'sd10430;
			5'd17: v = 33'sd5215;
			5'd18: v = 33'sd2607;
			5'd19: v = 33'sd1303;
			5'd20: v = 33'sd651;
			5'd21: v = 33'sd325;
			5'd22: v = 33'sd162;
			5'd23: v = 33'sd81;
			5'd24: v = 33'sd40;
			5'd25: v = 33'sd20;
			5'd26: v = 33'sd10;
			5'd27: v = 33'sd5;
			5'd28: v = 33'sd2;
			5'd29: v = 33'sd1;
			default: v = 33'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/rigid_body_point_kinematics_unit.sv =====
// Load, read, unknown command or out-of-range body: S_FETCH then done, no CORDIC or multiply.
// World point runs S_FETCH, S_ROT and part of S_MUL; point velocity and apply force run all of S_MUL.
// One command at a time; busy falls with the done beat, start taken then.
// Throughput is set by the shared CORDIC stage and the single 32x32 multiplier.
// Reset (arst_n low) clears the sequencer and the done strobe; the body table is not
// cleared and an entry reads undefined until loaded. Results cannot be stalled.
// ----------------------------------------------------------------------------
// rigid_body_point_kinematics_unit: 2-D rigid body table with point kinematics
// Load bodies, apply forces at local points, query point velocity, local to
// world transform and read force/torque accumulators. Q16.16 fixed point.
// ----------------------------------------------------------------------------
module rigid_body_point_kinematics_unit import rbpk_pkg::*; #(
	parameter int BODY_COUNT   = 64,
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	output logic     done,
	output result_t  result
);

	localparam int AW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
	localparam logic signed [65:0] HALF_Q  = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] HALF_30 = 66'sd1 <<< 29;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_ROT   = 4'b0100,
		S_MUL   = 4'b1000
	} state_t;

	state_t state_q;
	logic [3:0] k_q;            // multiply sequence step

	// body table: kinematics and accumulators, one read and one write port each
	kin_t kin_mem [BODY_COUNT];
	acc_t acc_mem [BODY_COUNT];
	kin_t kin_rd_q;
	acc_t acc_rd_q;

	in_item_t item_q;
	logic [AW-1:0] addr_q;

	logic kin_we, acc_we;
	acc_t acc_wd;

	// datapath registers
	logic signed [63:0] prod_q;
	logic signed [64:0] t_q;
	logic signed [35:0] ox_q, oy_q;
	logic signed [65:0] r1_q, r2_q;

	logic done_q;
	result_t result_q;

	// CORDIC
	cord_ctl_t cctl;
	logic signed [31:0] cos_v, sin_v;
	logic cord_last;

	rbpk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cctl),
		.angle (kin_rd_q.angle),
		.cos_v (cos_v),
		.sin_v (sin_v),
		.last  (cord_last)
	);

	logic in_range, cmd_rot;
	assign in_range = (32'(item_q.body) < BODY_COUNT);
	assign cmd_rot  = (item_q.cmd == CMD_FORCE) || (item_q.cmd == CMD_VEL) ||
	                  (item_q.cmd == CMD_WORLD);

	assign cctl.init = (state_q == S_FETCH) && in_range && cmd_rot;
	assign cctl.step = (state_q == S_ROT);

	// clamped offsets for the velocity and torque products
	logic signed [31:0] oxc, oyc;
	always_comb begin
		if (ox_q > 36'sd2147483647)       oxc = 32'sh7FFFFFFF;
		else if (ox_q < -36'sd2147483647) oxc = -32'sh7FFFFFFF;
		else                              oxc = ox_q[31:0];
		if (oy_q > 36'sd2147483647)       oyc = 32'sh7FFFFFFF;
		else if (oy_q < -36'sd2147483647) oyc = -32'sh7FFFFFFF;
		else                              oyc = oy_q[31:0];
	end

	// shared multiplier operand select
	logic signed [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (k_q)
			4'd0: begin mul_a = cos_v; mul_b = item_q.point_x; end
			4'd1: begin mul_a = sin_v; mul_b = item_q.point_y; end
			4'd2: begin mul_a = sin_v; mul_b = item_q.point_x; end
			4'd3: begin mul_a = cos_v; mul_b = item_q.point_y; end
			4'd5: begin
				if (item_q.cmd == CMD_VEL) begin
					mul_a = kin_rd_q.omega; mul_b = oyc;
				end else begin
					mul_a = oxc; mul_b = item_q.force_y;
				end
			end
			4'd6: begin
				if (item_q.cmd == CMD_VEL) begin
					mul_a = kin_rd_q.omega; mul_b = oxc;
				end else begin
					mul_a = oyc; mul_b = item_q.force_x;
				end
			end
			default: ;
		endcase
	end

	// rotated offset sums and rounding
	logic signed [65:0] rot_sum, r1_in, r2_in;
	always_comb begin
		if (k_q == 4'd2) rot_sum = 66'(t_q) - 66'(prod_q) + HALF_30;
		else             rot_sum = 66'(t_q) + 66'(prod_q) + HALF_30;
		if (item_q.cmd == CMD_FORCE) r1_in = 66'(t_q) - 66'(prod_q) + HALF_Q;
		else                         r1_in = 66'(t_q) + HALF_Q;
		r2_in = 66'(prod_q) + HALF_Q;
	end

	// final results
	logic signed [31:0] world_x, world_y, vel_x, vel_y;
	always_comb begin
		world_x = sat32(68'(ox_q) + 68'(kin_rd_q.pos_x));
		world_y = sat32(68'(oy_q) + 68'(kin_rd_q.pos_y));
		vel_x   = sat32(68'(kin_rd_q.vel_x) - 68'(r1_q));
		vel_y   = sat32(68'(kin_rd_q.vel_y) + 68'(r2_q));
		acc_wd.force_x = sat32(68'(acc_rd_q.force_x) + 68'(item_q.force_x));
		acc_wd.force_y = sat32(68'(acc_rd_q.force_y) + 68'(item_q.force_y));
		acc_wd.torque  = sat32(68'(acc_rd_q.torque) + 68'(r1_q));
	end

	assign kin_we = (state_q == S_FETCH) && in_range && (item_q.cmd == CMD_LOAD);
	assign acc_we = kin_we ||
	                ((state_q == S_MUL) && (k_q == 4'd8) && (item_q.cmd == CMD_FORCE));

	// table ports
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kin_rd_q <= kin_mem[AW'(item.body)];
		end
		if (kin_we) begin
			kin_mem[addr_q] <= '{pos_x: item_q.load_pos_x, pos_y: item_q.load_pos_y,
			                     angle: item_q.load_angle, vel_x: item_q.load_vel_x,
			                     vel_y: item_q.load_vel_y, omega: item_q.load_omega};
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			acc_rd_q <= acc_mem[AW'(item.body)];
		end
		if (acc_we) begin
			acc_mem[addr_q] <= kin_we ? acc_t'('0) : acc_wd;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
			addr_q <= AW'(item.body);
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_a * mul_b;
			case (k_q)
				4'd1, 4'd3, 4'd6: t_q <= 65'(prod_q);
				4'd2: ox_q <= 36'(rot_sum >>> 30);
				4'd4: oy_q <= 36'(rot_sum >>> 30);
				4'd7: begin
					r1_q <= r1_in >>> FRAC_BITS;
					r2_q <= r2_in >>> FRAC_BITS;
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_FETCH;
				end
				S_FETCH: begin
					result_q <= '0;
					if (in_range && cmd_rot) begin
						state_q <= S_ROT;
					end else begin
						// load, read, unknown code or body out of range
						if (in_range && (item_q.cmd == CMD_READ)) begin
							result_q <= '{result_x: acc_rd_q.force_x,
							              result_y: acc_rd_q.force_y,
							              result_torque: acc_rd_q.torque};
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ROT: begin
					if (cord_last) begin
						k_q     <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					k_q <= k_q + 4'd1;
					if ((k_q == 4'd5) && (item_q.cmd == CMD_WORLD)) begin
						result_q <= '{result_x: world_x, result_y: world_y,
						              result_torque: 32'sd0};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (k_q == 4'd8) begin
						if (item_q.cmd == CMD_VEL) begin
							result_q <= '{result_x: vel_x, result_y: vel_y,
							              result_torque: 32'sd0};
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/rbpk_cordic.sv =====
// ----------------------------------------------------------------------------
// rbpk_cordic: iterative CORDIC rotation, one micro-rotation per step
// Produces cos and sin of a 16-bit binary angle in Q2.30.
// ----------------------------------------------------------------------------
module rbpk_cordic import rbpk_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cord_ctl_t          ctl,
	input  logic [15:0]        angle,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v,
	output logic               last
);

	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic               flip_q;
	logic [4:0]         i_q;

	logic [31:0]        z32;
	logic signed [32:0] z_in;
	logic               flip_in;
	logic signed [33:0] dx, dy;
	logic signed [32:0] at;

	assign z32     = {angle, 16'h0000};
	assign z_in    = {z32[31], z32};
	assign flip_in = (z_in > 33'sd1073741824) || (z_in < -33'sd1073741824);
	assign dx      = y_q >>> i_q;
	assign dy      = x_q >>> i_q;
	assign at      = atan_at(i_q);
	assign last    = (i_q == 5'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (ctl.init) begin
			i_q <= '0;
		end else if (ctl.step) begin
			i_q <= i_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			x_q    <= CORDIC_GAIN_INV;
			y_q    <= '0;
			flip_q <= flip_in;
			// half-turn fold keeps the residual within +-90 degrees
			z_q    <= flip_in ? {~z32[31], ~z32[31], z32[30:0]} : z_in;
		end else if (ctl.step) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_v = 32'(flip_q ? -x_q : x_q);
	assign sin_v = 32'(flip_q ? -y_q : y_q);

endmodule

// ===== src/rbpk_checker.sv =====
// ----------------------------------------------------------------------------
// rbpk_checker: port-level checks of the command handshake
// Watches start/busy/done of the kinematics unit over time.
// ----------------------------------------------------------------------------
module rbpk_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted command occupies the unit
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// the result beat closes the command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while still busy");

	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a command");

	// one result beat per command
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

endmodule

bind rigid_body_point_kinematics_unit rbpk_checker u_rbpk_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
